// ===== sv/brim_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the bilinear image resampler.
package brim_pkg;

	localparam int PIX_W   = 8;
	localparam int POS_W   = 9;
	localparam int SW_W    = 10;
	localparam int SH_W    = 9;
	localparam int CR_W    = 25;
	localparam int RR_W    = 24;
	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 17;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int FRAC_W  = 16;
	localparam int X0_W    = POS_W + CR_W - FRAC_W;
	localparam int Y0_W    = POS_W + RR_W - FRAC_W;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [1:0] REG_COL_RATIO  = 2'd2;
	localparam logic [1:0] REG_ROW_RATIO  = 2'd3;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	localparam logic [SW_W-1:0] SRC_WIDTH_RST  = 10'd320;
	localparam logic [SH_W-1:0] SRC_HEIGHT_RST = 9'd240;
	localparam logic [CR_W-1:0] COL_RATIO_RST  = 25'd131072;
	localparam logic [RR_W-1:0] ROW_RATIO_RST  = 24'd98304;

	localparam logic [MUL_B_W-1:0] ONE_Q16 = 17'h10000;

	typedef struct packed {
		logic [SW_W-1:0] src_width;
		logic [SH_W-1:0] src_height;
		logic [CR_W-1:0] col_ratio;
		logic [RR_W-1:0] row_ratio;
	} brim_cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MULX,
		ST_MULY,
		ST_SPLIT,
		ST_READ,
		ST_WX,
		ST_WY,
		ST_ACC,
		ST_DONE
	} brim_state_t;

endpackage

// ===== sv/brim_mul.sv =====
`timescale 1ns / 1ps
// Shared unsigned multiplier with a registered product.
module brim_mul import brim_pkg::*; (
	input  logic               clk,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [PROD_W-1:0]  prod
);

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

// ===== sv/brim_frame_mem.sv =====
`timescale 1ns / 1ps
// Single-port frame store with a registered read.
module brim_frame_mem import brim_pkg::*; #(
	parameter int DEPTH = 131072,
	parameter int AW    = 17
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [PIX_W-1:0] wdata,
	output logic [PIX_W-1:0] rdata
);

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/brim_regs.sv =====
`timescale 1ns / 1ps
// APB configuration registers of the resampler.
module brim_regs import brim_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output brim_cfg_t          cfg
);

	brim_cfg_t cfg_q;
	logic      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width  <= SRC_WIDTH_RST;
			cfg_q.src_height <= SRC_HEIGHT_RST;
			cfg_q.col_ratio  <= COL_RATIO_RST;
			cfg_q.row_ratio  <= ROW_RATIO_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_SRC_WIDTH:  cfg_q.src_width  <= pwdata[SW_W-1:0];
				REG_SRC_HEIGHT: cfg_q.src_height <= pwdata[SH_W-1:0];
				REG_COL_RATIO:  cfg_q.col_ratio  <= pwdata[CR_W-1:0];
				REG_ROW_RATIO:  cfg_q.row_ratio  <= pwdata[RR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SRC_WIDTH:  prdata = PDATA_W'(cfg_q.src_width);
			REG_SRC_HEIGHT: prdata = PDATA_W'(cfg_q.src_height);
			REG_COL_RATIO:  prdata = PDATA_W'(cfg_q.col_ratio);
			REG_ROW_RATIO:  prdata = PDATA_W'(cfg_q.row_ratio);
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/bilinear_image_resampler_core.sv =====
`timescale 1ns / 1ps
// Bilinear image resampler: an 8-bit gray frame store is filled by load items
// (req_type 0) and sampled by sample items (req_type 1), which map the output
// position through the Q16 ratios and return the bilinear sum of the four
// neighbours, neighbours outside the frame counting as zero. One item is
// worked on at a time, and the next item is accepted only once the last one
// is through. The sample time is set by the single shared 25x17 multiplier,
// which forms both source coordinates and then two products per neighbour,
// and by the one-port frame memory, read once per neighbour.
// A finished result waits in an output register, so the next item can be
// accepted while it is still pending; a sample that finishes while that
// register is still full waits until its transfer has gone. The frame store
// has no reset; reading a pixel that was never loaded gives an undefined value.
module bilinear_image_resampler_core import brim_pkg::*; #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [POS_W-1:0]   pos_row,
	input  logic [POS_W-1:0]   pos_col,
	input  logic [PIX_W-1:0]   pixel_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PIX_W-1:0]   pixel_out
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int NX_W  = X0_W + 1;
	localparam int NY_W  = Y0_W + 1;

	brim_cfg_t   cfg;
	brim_state_t state_q, state_d;

	logic [POS_W-1:0]   row_q, col_q;
	logic [PIX_W-1:0]   pix_q;
	logic [X0_W-1:0]    x0_q;
	logic [Y0_W-1:0]    y0_q;
	logic [FRAC_W-1:0]  fx_q, fy_q;
	logic [1:0]         nb_q;
	logic               inside_q;
	logic [PROD_W-1:0]  acc_q;
	logic               out_valid_q;
	logic [PIX_W-1:0]   pixel_out_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod;
	logic               mem_we;
	logic [AW-1:0]      mem_addr;
	logic [PIX_W-1:0]   mem_rdata;

	logic [NX_W-1:0]    nx;
	logic [NY_W-1:0]    ny;
	logic               nb_inside;
	logic               load_ok;
	logic [MUL_B_W-1:0] wx, wy;
	logic [PIX_W-1:0]   nb_pix;
	logic               out_free;

	brim_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	brim_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	brim_frame_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (pix_q),
		.rdata (mem_rdata)
	);

	// Neighbour order: bit 0 of nb_q steps the column, bit 1 the row.
	assign nx = NX_W'(x0_q) + NX_W'(nb_q[0]);
	assign ny = NY_W'(y0_q) + NY_W'(nb_q[1]);

	assign nb_inside = (nx < NX_W'(MAX_WIDTH)) && (nx < NX_W'(cfg.src_width)) &&
		(ny < NY_W'(MAX_HEIGHT)) && (ny < NY_W'(cfg.src_height));

	assign load_ok = (32'(row_q) < MAX_HEIGHT) && (32'(col_q) < MAX_WIDTH);

	assign wx     = nb_q[0] ? MUL_B_W'(fx_q) : ONE_Q16 - MUL_B_W'(fx_q);
	assign wy     = nb_q[1] ? MUL_B_W'(fy_q) : ONE_Q16 - MUL_B_W'(fy_q);
	assign nb_pix = inside_q ? mem_rdata : '0;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (req_type == REQ_SAMPLE) ? ST_MULX : ST_LOAD;
				end
			end
			ST_LOAD:  state_d = ST_IDLE;
			ST_MULX:  state_d = ST_MULY;
			ST_MULY:  state_d = ST_SPLIT;
			ST_SPLIT: state_d = ST_READ;
			ST_READ:  state_d = ST_WX;
			ST_WX:    state_d = ST_WY;
			ST_WY:    state_d = ST_ACC;
			ST_ACC:   state_d = (nb_q == 2'd3) ? ST_DONE : ST_READ;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mem_we   = 1'b0;
		mem_addr = AW'(ny) * AW'(MAX_WIDTH) + AW'(nx);
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_LOAD: begin
				mem_we   = load_ok;
				mem_addr = AW'(row_q) * AW'(MAX_WIDTH) + AW'(col_q);
			end
			ST_MULX: begin
				mul_a = cfg.col_ratio;
				mul_b = MUL_B_W'(col_q);
			end
			ST_MULY: begin
				mul_a = MUL_A_W'(cfg.row_ratio);
				mul_b = MUL_B_W'(row_q);
			end
			ST_WX: begin
				mul_a = MUL_A_W'(nb_pix);
				mul_b = wx;
			end
			ST_WY: begin
				// pixel times one weight stays below 2^24
				mul_a = prod[MUL_A_W-1:0];
				mul_b = wy;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			row_q <= pos_row;
			col_q <= pos_col;
			pix_q <= pixel_in;
		end
		if (state_q == ST_MULY) begin
			x0_q <= prod[FRAC_W +: X0_W];
			fx_q <= prod[FRAC_W-1:0];
		end
		if (state_q == ST_SPLIT) begin
			y0_q  <= prod[FRAC_W +: Y0_W];
			fy_q  <= prod[FRAC_W-1:0];
			nb_q  <= 2'd0;
			acc_q <= '0;
		end
		if (state_q == ST_READ) begin
			inside_q <= nb_inside;
		end
		if (state_q == ST_ACC) begin
			acc_q <= acc_q + prod;
			nb_q  <= nb_q + 2'd1;
		end
		if (state_q == ST_DONE && out_free) begin
			pixel_out_q <= acc_q[32 +: PIX_W];
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;

endmodule
